@@ rtl/ppoq_pkg.sv @@
// Shared types, constants and codes of the paced packet output queue.
package ppoq_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int SLOT_BYTES_DEF  = 64;
    localparam int CMDQ_DEPTH      = 4;

    localparam int GAP_W      = 16;
    localparam int LIMIT_W    = 7;
    localparam int PEND_W     = 6;
    localparam int SLOT_MAX_W = 8;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [GAP_W-1:0]   GAP_RESET   = 16'd10;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    localparam logic REG_GAP   = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        F_PUSH = 2'd0,
        F_TICK = 2'd1,
        F_TAKE = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        K_ACCEPT   = 2'd0,
        K_REJECT   = 2'd1,
        K_NOTREADY = 2'd2,
        K_BYTE     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        B_IDLE,
        B_LENW,
        B_STREAM
    } t_bstate;

    typedef logic [PEND_W-1:0]     t_pend;
    typedef logic [SLOT_MAX_W-1:0] t_slot;

    typedef struct packed {
        logic [1:0] func;
        logic       has_byte;
        logic [7:0] push_byte;
        logic       push_last;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_byte;
        logic       out_last;
        t_pend      pending_count;
        logic       is_full;
    } t_out_item;

    typedef struct packed {
        t_kind kind;
        t_pend pending;
        logic  full;
        t_slot slot;
    } t_cmd;

endpackage

@@ rtl/ppoq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ppoq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ppoq_cmdq.sv @@
// Short command queue between the front classifier and the back release engine.
module ppoq_cmdq
    import ppoq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    t_cmd             r_mem [CMDQ_DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == CNT_W'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("command pushed into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("command popped from empty queue");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CMDQ_DEPTH)) else $error("command queue count overflow");

endmodule

@@ rtl/ppoq_front.sv @@
// Front part: accepts items, stores packets, keeps queue state and the gap timer.
module ppoq_front
    import ppoq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int SLOT_BYTES  = SLOT_BYTES_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    input  t_in_item                                    i_data,
    output logic                                        o_stall,
    input  logic [GAP_W-1:0]                            i_gap,
    input  logic [LIMIT_W-1:0]                          i_limit,
    input  logic                                        i_q_full,
    output logic                                        o_q_push,
    output t_cmd                                        o_q_data,
    input  logic                                        i_rel_done,
    output logic                                        o_byte_we,
    output logic [$clog2(QUEUE_DEPTH*SLOT_BYTES)-1:0]   o_byte_waddr,
    output logic [7:0]                                  o_byte_wdata,
    output logic                                        o_len_we,
    output logic [$clog2(QUEUE_DEPTH)-1:0]              o_len_waddr,
    output logic [$clog2(SLOT_BYTES+1)-1:0]             o_len_wdata
);

    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int LEN_W  = $clog2(SLOT_BYTES + 1);
    localparam int BA_W   = $clog2(QUEUE_DEPTH * SLOT_BYTES);
    localparam int REL_W  = $clog2(CMDQ_DEPTH + 2);

    logic [SLOT_W-1:0]  r_head, n_head;
    logic [SLOT_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [LEN_W-1:0]   r_len, n_len;
    logic               r_drop, n_drop;
    logic [GAP_W-1:0]   r_gap, n_gap;
    logic [REL_W-1:0]   r_rel_out, n_rel_out;

    logic               accept;
    logic               is_full;
    logic [LIMIT_W-1:0] lim;
    logic               store;
    logic               drop_tmp;
    logic [LEN_W-1:0]   len_tmp;
    logic               reject;
    logic               rel_inc;
    logic [CNT_W-1:0]   cmd_cnt;
    t_kind              cmd_kind;

    assign o_stall = i_q_full ||
                     ((r_rel_out != '0) && (i_data.func == F_PUSH));
    assign accept  = i_valid && !o_stall;
    assign is_full = (r_count == CNT_W'(QUEUE_DEPTH));
    assign lim     = (i_limit > LIMIT_W'(SLOT_BYTES)) ? LIMIT_W'(SLOT_BYTES) : i_limit;

    assign store    = i_data.has_byte && !r_drop && !((r_len == '0) && is_full) &&
                      (LIMIT_W'(r_len) < lim);
    assign drop_tmp = r_drop || (i_data.has_byte && !r_drop && !store);
    assign len_tmp  = r_len + LEN_W'(store);
    assign reject   = drop_tmp || (len_tmp == '0) || is_full;

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_len     = r_len;
        n_drop    = r_drop;
        n_gap     = r_gap;
        o_q_push  = 1'b0;
        o_byte_we = 1'b0;
        o_len_we  = 1'b0;
        rel_inc   = 1'b0;
        cmd_cnt   = r_count;
        cmd_kind  = K_NOTREADY;
        if (accept) begin
            case (i_data.func)
                F_PUSH: begin
                    o_byte_we = store;
                    if (i_data.push_last) begin
                        o_q_push = 1'b1;
                        n_len    = '0;
                        n_drop   = 1'b0;
                        if (reject) begin
                            cmd_kind = K_REJECT;
                        end else begin
                            cmd_kind = K_ACCEPT;
                            o_len_we = 1'b1;
                            n_tail   = (r_tail == SLOT_W'(QUEUE_DEPTH - 1)) ?
                                       '0 : r_tail + SLOT_W'(1);
                            n_count  = r_count + CNT_W'(1);
                            cmd_cnt  = n_count;
                        end
                    end else begin
                        n_len  = len_tmp;
                        n_drop = drop_tmp;
                    end
                end
                F_TICK: begin
                    if (r_gap != '0) begin
                        n_gap = r_gap - GAP_W'(1);
                    end
                end
                F_TAKE: begin
                    o_q_push = 1'b1;
                    if ((r_count == '0) || (r_gap != '0)) begin
                        cmd_kind = K_NOTREADY;
                    end else begin
                        cmd_kind = K_BYTE;
                        rel_inc  = 1'b1;
                        n_head   = (r_head == SLOT_W'(QUEUE_DEPTH - 1)) ?
                                   '0 : r_head + SLOT_W'(1);
                        n_count  = r_count - CNT_W'(1);
                        n_gap    = i_gap;
                        cmd_cnt  = n_count;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_rel_out = r_rel_out;
        if (rel_inc && !i_rel_done) begin
            n_rel_out = r_rel_out + REL_W'(1);
        end else if (!rel_inc && i_rel_done) begin
            n_rel_out = r_rel_out - REL_W'(1);
        end
    end

    assign o_q_data.kind    = cmd_kind;
    assign o_q_data.pending = t_pend'(cmd_cnt);
    assign o_q_data.full    = (cmd_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_q_data.slot    = t_slot'(r_head);

    assign o_byte_waddr = BA_W'(r_tail) * BA_W'(SLOT_BYTES) + BA_W'(r_len);
    assign o_byte_wdata = i_data.push_byte;
    assign o_len_waddr  = r_tail;
    assign o_len_wdata  = len_tmp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_len     <= '0;
            r_drop    <= 1'b0;
            r_gap     <= '0;
            r_rel_out <= '0;
        end else begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_len     <= n_len;
            r_drop    <= n_drop;
            r_gap     <= n_gap;
            r_rel_out <= n_rel_out;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH)) else $error("packet count above depth");
    a_rel_done_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rel_done |-> (r_rel_out != '0)) else $error("release done without one open");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |-> !i_q_full) else $error("command issued into full queue");

endmodule

@@ rtl/ppoq_back.sv @@
// Back part: turns commands into results and streams released packets from storage.
module ppoq_back
    import ppoq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int SLOT_BYTES  = SLOT_BYTES_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_q_empty,
    input  t_cmd                                        i_q_data,
    output logic                                        o_q_pop,
    output logic                                        o_len_re,
    output logic [$clog2(QUEUE_DEPTH)-1:0]              o_len_raddr,
    input  logic [$clog2(SLOT_BYTES+1)-1:0]             i_len_rdata,
    output logic                                        o_byte_re,
    output logic [$clog2(QUEUE_DEPTH*SLOT_BYTES)-1:0]   o_byte_raddr,
    input  logic [7:0]                                  i_byte_rdata,
    output logic                                        o_rel_done,
    output logic                                        o_out_valid,
    output t_out_item                                   o_out_data,
    input  logic                                        i_out_stall
);

    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int LEN_W  = $clog2(SLOT_BYTES + 1);
    localparam int BA_W   = $clog2(QUEUE_DEPTH * SLOT_BYTES);

    t_bstate           r_state, n_state;
    logic [SLOT_W-1:0] r_slot;
    t_pend             r_pend_cnt;
    logic              r_full;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_issue;
    logic              r_pend;
    logic              r_pend_last;
    logic              r_out_valid;
    t_out_item         r_out;

    logic              out_free;
    logic              load_cmd;
    logic              load_byte;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_q_pop    = 1'b0;
        o_len_re   = 1'b0;
        o_byte_re  = 1'b0;
        load_cmd   = 1'b0;
        load_byte  = 1'b0;
        o_rel_done = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    if (i_q_data.kind == K_BYTE) begin
                        o_q_pop  = 1'b1;
                        o_len_re = 1'b1;
                    end else if (out_free) begin
                        o_q_pop  = 1'b1;
                        load_cmd = 1'b1;
                    end
                end
            end
            B_LENW: begin
            end
            B_STREAM: begin
                load_byte  = r_pend && out_free;
                o_byte_re  = (r_issue != r_len) && (!r_pend || load_byte);
                o_rel_done = load_byte && r_pend_last;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (o_len_re) begin
                    n_state = B_LENW;
                end
            end
            B_LENW: begin
                n_state = B_STREAM;
            end
            B_STREAM: begin
                if (o_rel_done) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    assign o_len_raddr  = i_q_data.slot[SLOT_W-1:0];
    assign o_byte_raddr = BA_W'(r_slot) * BA_W'(SLOT_BYTES) + BA_W'(r_issue);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_byte_re) begin
                r_pend <= 1'b1;
            end else if (load_byte) begin
                r_pend <= 1'b0;
            end
            if (load_cmd || load_byte) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_len_re) begin
            r_slot     <= i_q_data.slot[SLOT_W-1:0];
            r_pend_cnt <= i_q_data.pending;
            r_full     <= i_q_data.full;
        end
        if (r_state == B_LENW) begin
            r_len   <= i_len_rdata;
            r_issue <= '0;
        end else if (o_byte_re) begin
            r_issue     <= r_issue + LEN_W'(1);
            r_pend_last <= (r_issue + LEN_W'(1) == r_len);
        end
        if (load_cmd) begin
            r_out.kind          <= i_q_data.kind;
            r_out.out_byte      <= '0;
            r_out.out_last      <= 1'b1;
            r_out.pending_count <= i_q_data.pending;
            r_out.is_full       <= i_q_data.full;
        end else if (load_byte) begin
            r_out.kind          <= K_BYTE;
            r_out.out_byte      <= i_byte_rdata;
            r_out.out_last      <= r_pend_last;
            r_out.pending_count <= r_pend_cnt;
            r_out.is_full       <= r_full;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_STREAM) |-> (r_issue <= r_len)) else $error("read beyond packet");
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid) else $error("stalled result lost");
    a_done_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rel_done |-> (r_issue == r_len)) else $error("release ended early");
    a_lenw_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_LENW) |-> $past(o_len_re)) else $error("length wait without read");

endmodule

@@ rtl/paced_packet_output_queue.sv @@
// Top level of the paced packet output queue: configuration port and part wiring.
//
// Items enter on i_in_valid / o_in_stall with payload i_in_data; results leave on
// o_out_valid / i_out_stall with payload o_out_data. A transfer happens on a rising
// edge with valid high and stall low.
// Push items store at most one byte each, one per cycle while o_in_stall is low; a push
// with the last mark or a refused take yields one result. A granted take yields one
// result per packet byte. Ticks and unmarked pushes yield none.
// A single result is offered from the result register once its command has passed the
// command queue; a release first passes the command queue and the registered reads of
// the length table and the byte store, then offers one byte per cycle unless stalled.
// Up to four commands wait between the front and the release engine; the front stalls
// when that queue is full, and holds pushes while a granted release is not yet done.
// When the receiver stalls, the result register holds and the queue fills behind it.
// Reset empties the queue, clears the gap timer so no gap holds the first take, and sets
// the gap to 10 ticks and the size limit to 64 bytes. Packet storage is not cleared.
// Configuration: register 0 (byte 0) release gap, register 1 (byte 4) size limit.
module paced_packet_output_queue
    import ppoq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int SLOT_BYTES  = SLOT_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               i_in_valid,
    input  t_in_item           i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output t_out_item          o_out_data,
    input  logic               i_out_stall
);

    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int LEN_W  = $clog2(SLOT_BYTES + 1);
    localparam int BA_W   = $clog2(QUEUE_DEPTH * SLOT_BYTES);

    logic [GAP_W-1:0]   r_gap;
    logic [LIMIT_W-1:0] r_limit;

    logic               q_push, q_pop, q_full, q_empty;
    t_cmd               q_wdata, q_rdata;
    logic               rel_done;
    logic               byte_we, byte_re;
    logic [BA_W-1:0]    byte_waddr, byte_raddr;
    logic [7:0]         byte_wdata, byte_rdata;
    logic               len_we, len_re;
    logic [SLOT_W-1:0]  len_waddr, len_raddr;
    logic [LEN_W-1:0]   len_wdata, len_rdata;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap   <= GAP_RESET;
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[PADDR_W-1])
                REG_GAP:   r_gap   <= pwdata[GAP_W-1:0];
                REG_LIMIT: r_limit <= pwdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[PADDR_W-1])
            REG_GAP:   prdata = PDATA_W'(r_gap);
            REG_LIMIT: prdata = PDATA_W'(r_limit);
            default:   prdata = '0;
        endcase
    end

    ppoq_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .SLOT_BYTES  (SLOT_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_data       (i_in_data),
        .o_stall      (o_in_stall),
        .i_gap        (r_gap),
        .i_limit      (r_limit),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_data     (q_wdata),
        .i_rel_done   (rel_done),
        .o_byte_we    (byte_we),
        .o_byte_waddr (byte_waddr),
        .o_byte_wdata (byte_wdata),
        .o_len_we     (len_we),
        .o_len_waddr  (len_waddr),
        .o_len_wdata  (len_wdata)
    );

    ppoq_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    ppoq_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH * SLOT_BYTES)
    ) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (byte_we),
        .i_waddr (byte_waddr),
        .i_wdata (byte_wdata),
        .i_re    (byte_re),
        .i_raddr (byte_raddr),
        .o_rdata (byte_rdata)
    );

    ppoq_ram #(
        .WIDTH (LEN_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_re    (len_re),
        .i_raddr (len_raddr),
        .o_rdata (len_rdata)
    );

    ppoq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .SLOT_BYTES  (SLOT_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_data     (q_rdata),
        .o_q_pop      (q_pop),
        .o_len_re     (len_re),
        .o_len_raddr  (len_raddr),
        .i_len_rdata  (len_rdata),
        .o_byte_re    (byte_re),
        .o_byte_raddr (byte_raddr),
        .i_byte_rdata (byte_rdata),
        .o_rel_done   (rel_done),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall)
    );

endmodule
